>>> rtl/tlbrp_pkg.sv
// package for the tlb region entry planner
// page sizes, result codes and the step record; no dependencies
`default_nettype none

package tlbrp_pkg;

    localparam int AddrW = 32;
    localparam int SlotW = 6;
    localparam int CountW = 6;

    localparam logic [SlotW-1:0] SLOT_LIMIT = 6'd32;
    localparam logic [SlotW-1:0] SLOT_TOP = 6'd63;
    localparam logic [CountW-1:0] RESULT_CAP = 6'd33;

    localparam logic [AddrW-1:0] SIZE_4K = 32'h0000_1000;
    localparam logic [AddrW-1:0] SIZE_64K = 32'h0001_0000;
    localparam logic [AddrW-1:0] SIZE_1M = 32'h0010_0000;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_LARGE = 2'd1;
    localparam logic [1:0] KIND_SMALL = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOMAP = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic             entry_valid;
        logic [AddrW-1:0] entry_phys;
        logic [AddrW-1:0] entry_virt;
        logic [1:0]       page_kind;
        logic [SlotW-1:0] slot_index;
        logic [1:0]       status;
        logic             last;
    } result_t;

    typedef struct packed {
        result_t          res;
        logic [AddrW-1:0] phys_next;
        logic [AddrW-1:0] virt_next;
        logic [AddrW-1:0] rem_next;
        logic [SlotW-1:0] slot_next;
    } step_t;

endpackage

`default_nettype wire

>>> rtl/tlbrp_if.sv
// valid/ready channel interfaces for region requests and planned entries
// depends on nothing
`default_nettype none

interface tlbrp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_phys;
    logic [31:0] start_virt;
    logic [31:0] region_size;

    modport source (output valid, start_phys, start_virt, region_size, input ready);
    modport sink (input valid, start_phys, start_virt, region_size, output ready);
endinterface

interface tlbrp_out_if;
    logic        valid;
    logic        ready;
    logic        entry_valid;
    logic [31:0] entry_phys;
    logic [31:0] entry_virt;
    logic [1:0]  page_kind;
    logic [5:0]  slot_index;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, entry_valid, entry_phys, entry_virt, page_kind,
                    slot_index, status, last, input ready);
    modport sink (input valid, entry_valid, entry_phys, entry_virt, page_kind,
                  slot_index, status, last, output ready);
endinterface

`default_nettype wire

>>> rtl/tlbrp_step_unit.sv
// shared step unit: picks one page, advances addresses and remaining size
// depends on tlbrp_pkg
`default_nettype none

module tlbrp_step_unit (
    input  wire logic [31:0] phys,
    input  wire logic [31:0] virt,
    input  wire logic [31:0] rem,
    input  wire logic [5:0]  next_slot,
    input  wire logic [5:0]  count,
    input  wire logic        first,
    output tlbrp_pkg::step_t step
);
    import tlbrp_pkg::*;

    logic             a4;
    logic             a64;
    logic             a1m;
    logic             rem_ge_1m;
    logic             rem_ge_4k;
    logic             fits;
    logic [1:0]       kind;
    logic [AddrW-1:0] size;
    logic             full;

    assign a4 = (phys[11:0] == 12'd0);
    assign a64 = (phys[15:0] == 16'd0);
    assign a1m = (phys[19:0] == 20'd0);
    assign rem_ge_1m = (rem >= SIZE_1M);
    assign rem_ge_4k = (rem >= SIZE_4K);
    assign fits = a4 && rem_ge_4k;

    always_comb
    begin
        if (rem_ge_1m && a1m)
        begin
            kind = KIND_SECTION;
            size = SIZE_1M;
        end
        else if ((rem > SIZE_4K) && a64)
        begin
            kind = KIND_LARGE;
            size = SIZE_64K;
        end
        else
        begin
            kind = KIND_SMALL;
            size = SIZE_4K;
        end
    end

    assign full = (next_slot >= SLOT_LIMIT) || ((count + 6'd1) >= RESULT_CAP);

    always_comb
    begin
        step = '0;
        step.phys_next = phys + size;
        step.virt_next = virt + size;
        step.rem_next = rem - size;
        step.slot_next = next_slot;
        step.res.last = 1'b1;
        if (first && (next_slot > SLOT_LIMIT))
        begin
            step.res.status = STATUS_FULL;
        end
        else if (first && (rem == 32'd0))
        begin
            step.res.status = STATUS_OK;
        end
        else if (!fits)
        begin
            step.res.status = STATUS_NOMAP;
        end
        else
        begin
            step.res.entry_valid = 1'b1;
            step.res.entry_phys = phys;
            step.res.entry_virt = virt;
            step.res.page_kind = kind;
            step.res.slot_index = next_slot;
            step.res.status = full ? STATUS_FULL : STATUS_OK;
            step.res.last = full || (size >= rem);
            step.slot_next = (next_slot != SLOT_TOP) ? next_slot + 6'd1 : next_slot;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tlb_region_entry_planner.sv
// tlb region entry planner: n results per region, one per cycle when the
// receiver does not stall, through a registered output; the region port
// is busy for the whole walk. the region is registered first, then each
// step result is loaded into the output register. at most 33 results per
// region come from the single step unit, one page per cycle while output
// is free. reset (async, low) clears slot counter, sequencer, output valid.
`default_nettype none

module tlb_region_entry_planner (
    input wire logic  clk,
    input wire logic  rst_n,
    tlbrp_in_if.sink  region,
    tlbrp_out_if.source entry
);
    import tlbrp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             state_reg, state_next;
    logic [AddrW-1:0] phys_reg, phys_next;
    logic [AddrW-1:0] virt_reg, virt_next;
    logic [AddrW-1:0] rem_reg, rem_next;
    logic [SlotW-1:0] slot_reg, slot_next;
    logic [CountW-1:0] count_reg, count_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    step_t            step;
    logic             region_take;
    logic             out_free;
    logic             advance;

    // one shared step unit does page choice and all address arithmetic
    tlbrp_step_unit u_step (
        .phys      (phys_reg),
        .virt      (virt_reg),
        .rem       (rem_reg),
        .next_slot (slot_reg),
        .count     (count_reg),
        .first     (first_reg),
        .step      (step)
    );

    assign region.ready = (state_reg == ST_IDLE);
    assign region_take = region.valid && region.ready;

    // output register is free when empty or taken this cycle
    assign out_free = !out_valid_reg || entry.ready;
    assign advance = (state_reg == ST_WALK) && out_free;

    always_comb
    begin
        state_next = state_reg;
        phys_next = phys_reg;
        virt_next = virt_reg;
        rem_next = rem_reg;
        slot_next = slot_reg;
        count_next = count_reg;
        first_next = first_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !entry.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (region_take)
                begin
                    phys_next = region.start_phys;
                    virt_next = region.start_virt;
                    rem_next = region.region_size;
                    count_next = '0;
                    first_next = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    // load one result and step the walk
                    out_next = step.res;
                    out_valid_next = 1'b1;
                    slot_next = step.slot_next;
                    phys_next = step.phys_next;
                    virt_next = step.virt_next;
                    rem_next = step.rem_next;
                    count_next = count_reg + 6'd1;
                    first_next = 1'b0;
                    if (step.res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg <= '0;
            out_valid_reg <= 1'b0;
            first_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            out_valid_reg <= out_valid_next;
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        phys_reg <= phys_next;
        virt_reg <= virt_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end

    assign entry.valid = out_valid_reg;
    assign entry.entry_valid = out_reg.entry_valid;
    assign entry.entry_phys = out_reg.entry_phys;
    assign entry.entry_virt = out_reg.entry_virt;
    assign entry.page_kind = out_reg.page_kind;
    assign entry.slot_index = out_reg.slot_index;
    assign entry.status = out_reg.status;
    assign entry.last = out_reg.last;

endmodule

`default_nettype wire

>>> rtl/tlbrp_checker.sv
// port-level checker for the tlb region entry planner, bound to the top level
// depends on tlbrp_pkg and tlb_region_entry_planner
`default_nettype none

module tlbrp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       region_valid,
    input wire logic       region_ready,
    input wire logic       entry_vld,
    input wire logic       entry_rdy,
    input wire logic       entry_valid,
    input wire logic [31:0] entry_phys,
    input wire logic [5:0] slot_index,
    input wire logic [1:0] status,
    input wire logic       last
);
    import tlbrp_pkg::*;

    // a result without an entry always ends the region
    a_noentry_last: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_vld && !entry_valid) |-> last)
        else $error("result without entry is not last");

    // a result without an entry carries zero address and slot
    a_noentry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_vld && !entry_valid) |-> (entry_phys == 32'd0 && slot_index == 6'd0))
        else $error("result without entry has nonzero fields");

    // full status ends the walk
    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_vld && status == STATUS_FULL) |-> last)
        else $error("full status without last");

    // region port stays busy right after a region transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (region_valid && region_ready) |=> !region_ready)
        else $error("region accepted during walk");

    // taking a non-final result brings the next one in the following cycle
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_vld && entry_rdy && !last) |=> entry_vld)
        else $error("walk stalled after non-final result");

endmodule

bind tlb_region_entry_planner tlbrp_checker u_tlbrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .region_valid (region.valid),
    .region_ready (region.ready),
    .entry_vld    (entry.valid),
    .entry_rdy    (entry.ready),
    .entry_valid  (entry.entry_valid),
    .entry_phys   (entry.entry_phys),
    .slot_index   (entry.slot_index),
    .status       (entry.status),
    .last         (entry.last)
);

`default_nettype wire

>>> tb/tb.sv
// self-checking bench for tlb_region_entry_planner: region transactions in,
// planned tlb entries out, checked against an in-bench page planner
// depends on rtl/tlbrp_pkg.sv, rtl/tlbrp_if.sv and the planner rtl
module tb;

    import tlbrp_pkg::*;

    // ---------------------------------------------------------------
    // expected-entry tracker
    // keeps its own slot counter and turns each accepted region into the
    // entry results the planner must produce, in order
    // ---------------------------------------------------------------
    class region_plan_checker;
        result_t          planned_entries[$];
        logic [SlotW-1:0] slot_ctr;
        int               errors;
        int               checked;

        function new();
            slot_ctr = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int pending();
            return planned_entries.size();
        endfunction

        function void queue_result(logic v, logic [31:0] p, logic [31:0] vt,
                                   logic [1:0] k, logic [5:0] s,
                                   logic [1:0] st, logic l);
            result_t r;
            r = {v, p, vt, k, s, st, l};
            planned_entries.push_back(r);
        endfunction

        // walk one region exactly as the planner does
        function void plan_region(logic [31:0] phys_in, logic [31:0] virt_in,
                                  logic [31:0] size_in);
            logic [31:0]      phys;
            logic [31:0]      virt;
            logic [31:0]      step;
            logic [33:0]      done;
            logic [33:0]      total;
            logic [33:0]      rem;
            logic [1:0]       kind;
            logic [SlotW-1:0] slot;
            logic             fits;
            int               n;

            phys  = phys_in;
            virt  = virt_in;
            total = {2'b00, size_in};
            done  = '0;
            step  = '0;
            kind  = KIND_SECTION;
            n     = 0;

            if (slot_ctr > SLOT_LIMIT) begin
                queue_result(1'b0, '0, '0, '0, '0, STATUS_FULL, 1'b1);
                return;
            end
            if (size_in == '0) begin
                queue_result(1'b0, '0, '0, '0, '0, STATUS_OK, 1'b1);
                return;
            end

            while (done < total) begin
                rem  = total - done;
                fits = 1'b1;
                // page size comes from bytes left and physical alignment only
                if (phys[11:0] != '0) begin
                    fits = 1'b0;
                end
                else if (rem >= {2'b00, SIZE_1M}) begin
                    if (phys[19:0] == '0) begin
                        kind = KIND_SECTION;
                        step = SIZE_1M;
                    end
                    else if (phys[15:0] == '0) begin
                        kind = KIND_LARGE;
                        step = SIZE_64K;
                    end
                    else begin
                        kind = KIND_SMALL;
                        step = SIZE_4K;
                    end
                end
                else if (rem > {2'b00, SIZE_4K}) begin
                    if (phys[15:0] == '0) begin
                        kind = KIND_LARGE;
                        step = SIZE_64K;
                    end
                    else begin
                        kind = KIND_SMALL;
                        step = SIZE_4K;
                    end
                end
                else if (rem == {2'b00, SIZE_4K}) begin
                    kind = KIND_SMALL;
                    step = SIZE_4K;
                end
                else begin
                    fits = 1'b0;
                end

                if (!fits) begin
                    queue_result(1'b0, '0, '0, '0, '0, STATUS_NOMAP, 1'b1);
                    return;
                end

                // counter saturates at its top instead of wrapping
                slot = slot_ctr;
                if (slot_ctr != SLOT_TOP)
                    slot_ctr = slot_ctr + 1'b1;
                done = done + {2'b00, step};

                if (slot >= SLOT_LIMIT || n + 1 >= int'(RESULT_CAP)) begin
                    queue_result(1'b1, phys, virt, kind, slot, STATUS_FULL, 1'b1);
                    return;
                end
                queue_result(1'b1, phys, virt, kind, slot, STATUS_OK, done >= total);
                n    = n + 1;
                phys = phys + step;
                virt = virt + step;
            end
        endfunction

        task report(string msg);
            $display("mismatch at entry %0d: %s", checked, msg);
            errors = errors + 1;
        endtask

        task check_entry(result_t got);
            result_t want;
            if (planned_entries.size() == 0) begin
                report($sformatf("unexpected entry phys %h slot %0d status %0d",
                                 got.entry_phys, got.slot_index, got.status));
                checked = checked + 1;
                return;
            end
            want = planned_entries.pop_front();
            if (got.entry_valid !== want.entry_valid)
                report($sformatf("entry_valid %b, want %b", got.entry_valid, want.entry_valid));
            if (got.entry_phys !== want.entry_phys)
                report($sformatf("entry_phys %h, want %h", got.entry_phys, want.entry_phys));
            if (got.entry_virt !== want.entry_virt)
                report($sformatf("entry_virt %h, want %h", got.entry_virt, want.entry_virt));
            if (got.page_kind !== want.page_kind)
                report($sformatf("page_kind %0d, want %0d", got.page_kind, want.page_kind));
            if (got.slot_index !== want.slot_index)
                report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
            checked = checked + 1;
        endtask
    endclass

    // ---------------------------------------------------------------
    // bench constants
    // ---------------------------------------------------------------
    localparam int ITEMS_PER_PHASE = 36;   // four random phases, ~160 regions in all
    localparam int HOLD_LEN        = 200;  // long receiver hold-off
    localparam int TAIL_CYCLES     = 20;   // quiet wait after the last entry is back
    localparam int STALL_LIMIT     = 4000; // cycles with no transaction at all

    logic clk;
    logic rst_n;

    tlbrp_in_if  region_if ();
    tlbrp_out_if entry_if ();

    tlb_region_entry_planner DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .region (region_if),
        .entry  (entry_if)
    );

    region_plan_checker sb;

    // idle/stall chances in percent, changed between phases
    int  src_idle_pct;
    int  sink_stall_pct;
    // set by the stimulus to request one long hold-off on the entry side
    bit  hold_req;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // region side
    // ---------------------------------------------------------------

    // offer one region; returns in the time step of its transaction with
    // valid still high so back-to-back regions follow without a gap
    task automatic offer_region(logic [31:0] p, logic [31:0] v, logic [31:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            region_if.valid <= 1'b0;
            @(posedge clk);
        end
        region_if.valid       <= 1'b1;
        region_if.start_phys  <= p;
        region_if.start_virt  <= v;
        region_if.region_size <= s;
        do
            @(posedge clk);
        while (region_if.ready !== 1'b1);
        sb.plan_region(p, v, s);
    endtask

    // drop valid and hold the region side until every planned entry is back;
    // waits on the clock before checking, so valid is not set twice in a step
    task automatic wait_entries_drained();
        region_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // mostly well-formed regions (4K aligned, often 64K or 1M aligned,
    // modest sizes) plus noise: misaligned starts, tiny, zero or huge sizes
    task automatic random_region(output logic [31:0] p, output logic [31:0] v,
                                 output logic [31:0] s);
        int pick;
        pick = $urandom_range(99);
        v    = $urandom;
        if (pick < 70) begin
            p = $urandom & 32'hFFFF_F000;
            case ($urandom_range(2))
                0:       p = p & 32'hFFFF_0000;
                1:       p = p & 32'hFFF0_0000;
                default: p = p;
            endcase
            case ($urandom_range(3))
                0:       s = SIZE_4K;
                1:       s = $urandom_range(32'h1001, 32'h1_FFFF);
                2:       s = $urandom_range(1, 48) * SIZE_4K;
                default: s = $urandom_range(32'h10_0000, 32'h18_0000);
            endcase
        end
        else begin
            p = $urandom;
            case ($urandom_range(2))
                0:       s = $urandom;
                1:       s = $urandom_range(32'hFFF);
                default: s = '0;
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // entry side: random back-pressure, with one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : entry_sink
        int      hold_left;
        result_t got;
        hold_left = 0;
        entry_if.ready <= 1'b0;
        forever begin
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                entry_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else begin
                entry_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
            @(posedge clk);
            if (entry_if.valid === 1'b1 && entry_if.ready === 1'b1) begin
                got = {entry_if.entry_valid, entry_if.entry_phys, entry_if.entry_virt,
                       entry_if.page_kind, entry_if.slot_index, entry_if.status,
                       entry_if.last};
                sb.check_entry(got);
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ---------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((region_if.valid === 1'b1 && region_if.ready === 1'b1) ||
                (entry_if.valid === 1'b1 && entry_if.ready === 1'b1))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // main stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] p;
        logic [31:0] v;
        logic [31:0] s;

        sb             = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b0;

        region_if.valid       <= 1'b0;
        region_if.start_phys  <= '0;
        region_if.start_virt  <= '0;
        region_if.region_size <= '0;
        rst_n                 <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed regions, slot counter tallied alongside
        // zero size: one ok result, no entry
        offer_region(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        // all ones: misaligned start, cannot map
        offer_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // aligned start but under 4K to map
        offer_region(32'h0000_1000, 32'h1234_5000, 32'h0000_0FFF);
        // exactly 4K but start off by one byte
        offer_region(32'h0000_1001, 32'h0000_1000, 32'h0000_1000);
        // single small page, top virtual page (slot 0)
        offer_region(32'h0000_2000, 32'hFFFF_F000, 32'h0000_1000);
        // large page that maps more than asked (slot 1)
        offer_region(32'h0001_0000, 32'h8000_0000, 32'h0000_1001);
        // single section (slot 2)
        offer_region(32'h0010_0000, 32'h0000_0000, 32'h0010_0000);
        // two sections wrapping both addresses through zero (slots 3-4)
        offer_region(32'hFFF0_0000, 32'hFFF0_0000, 32'h0020_0000);
        // small, section, small with at least 1M left (slots 5-7)
        offer_region(32'h000F_F000, 32'h0000_0123, 32'h0010_2000);
        // two small pages then a sub-4K tail: cannot map after entries (8-9)
        offer_region(32'h0003_1000, 32'h4000_0000, 32'h0000_2800);
        // large under 1M+ then section (slots 10-11)
        offer_region(32'h000F_0000, 32'h7FFF_0000, 32'h0011_0000);
        // large wrapping physical, then small (slots 12-13)
        offer_region(32'hFFFF_0000, 32'hFFFF_F000, 32'h0001_1000);

        // back-pressure: entry side holds off while regions keep coming,
        // so the output register fills and the region port stalls
        hold_req = 1'b1;
        repeat (4) begin
            random_region(p, v, s);
            offer_region(p, v, s);
        end
        wait_entries_drained();

        // random phases: no idling, sender idle, receiver stall, both light;
        // the table fills early in these, after which every region is refused
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                random_region(p, v, s);
                offer_region(p, v, s);
            end
            // sender waits for the block to empty between phases
            wait_entries_drained();
        end

        // tail: a 32M region runs the table to its limit if the random part
        // did not, then regions arriving past the limit get one full result
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        offer_region(32'h0400_0000, 32'h0400_0000, 32'h0200_0000);
        offer_region(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        offer_region(32'h0000_2000, 32'h0000_2000, 32'h0000_1000);
        offer_region(32'h0000_0001, 32'h0000_0000, 32'h0000_0001);

        wait_entries_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
